/* hdl/clook_disk_scheduler_top_macros.svh */
`ifndef CLOOK_DISK_SCHEDULER_TOP_MACROS_SVH
`define CLOOK_DISK_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTH
// Check prop on every rising clock edge outside reset.
`define CLOOK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Check that cond is followed in the next cycle by res.
`define CLOOK_ASSERT_NEXT(lbl, clk, rst_n, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("assertion failed");
`else
`define CLOOK_ASSERT(lbl, clk, rst_n, prop)
`define CLOOK_ASSERT_NEXT(lbl, clk, rst_n, cond, res)
`endif

`endif

/* hdl/clook_pkg.sv */
package clook_pkg;

    localparam int MAX_REQUESTS_DEF = 8;
    localparam int TRACK_W          = 8;
    localparam int SEEK_W           = 12;
    localparam int TRACK_COUNT      = 256;

    localparam logic [SEEK_W-1:0] SEEK_MAX = 12'hFFF;

    typedef struct packed {
        logic               load;
        logic               step;
        logic [TRACK_W-1:0] track;
    } t_seek_cmd;

endpackage

/* hdl/clook_disk_scheduler_top.sv */
// C-LOOK disk scheduler.
// Input channel: present a request on i_request_track, i_head_position and
// i_last_request with start high; the transaction is taken at the rising edge
// where start is high and busy is low. i_head_position counts only with the
// request that has i_last_request set; that request closes the batch.
// Output channel: each result is on o_service_track, o_has_track,
// o_seek_total, o_last_in_run and o_overflow_flag for exactly one cycle with
// o_valid high. The receiver cannot stall; o_valid is a strobe.
// A request is kept in a sorted memory by insertion; stored entries above the
// new track are shifted up one place. The closing request then walks the
// memory once to split it at the head and once more to emit (one result per
// cycle except at the wrap to the lower tracks). The track memory has a
// single read port. A batch with nothing serviceable gives one result with
// o_has_track low.
// The next transaction is taken while the last result of a batch is on the
// output. Reset (i_rst_n low, synchronous) empties the batch and clears the
// seek accumulator; memory contents are not cleared.
`include "clook_disk_scheduler_top_macros.svh"

module clook_disk_scheduler_top #(
    parameter int MAX_REQUESTS = clook_pkg::MAX_REQUESTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [clook_pkg::TRACK_W-1:0]  i_request_track,
    input  logic [clook_pkg::TRACK_W-1:0]  i_head_position,
    input  logic                           i_last_request,
    output logic                           busy,
    output logic                           o_valid,
    output logic [clook_pkg::TRACK_W-1:0]  o_service_track,
    output logic                           o_has_track,
    output logic [clook_pkg::SEEK_W-1:0]   o_seek_total,
    output logic                           o_last_in_run,
    output logic                           o_overflow_flag
);

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int TW = clook_pkg::TRACK_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INS   = 7'b0000010,
        S_SHIFT = 7'b0000100,
        S_PLACE = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_EMPTY = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [TW-1:0] r_mem [MAX_REQUESTS];
    logic [TW-1:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [TW-1:0] mem_wdata;
    logic [CW-1:0] mem_raddr;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_lt, n_lt;
    logic [CW-1:0] r_le, n_le;
    logic          r_phase, n_phase;
    logic          r_pend, n_pend;
    logic          r_pend_last, n_pend_last;
    logic          r_dropped, n_dropped;
    logic          r_out_valid, n_out_valid;

    logic [TW-1:0] r_track, n_track;
    logic [TW-1:0] r_head, n_head;
    logic          r_last, n_last;
    logic [TW-1:0] r_out_track, n_out_track;
    logic          r_out_has, n_out_has;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic                 track_ok;
    logic                 ins_done;
    logic                 finish;
    clook_pkg::t_seek_cmd seek_cmd;

    assign track_ok = 17'(r_track) < 17'(clook_pkg::TRACK_COUNT);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_lt        = r_lt;
        n_le        = r_le;
        n_phase     = r_phase;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_dropped   = r_dropped;
        n_track     = r_track;
        n_head      = r_head;
        n_last      = r_last;
        n_out_valid = 1'b0;
        n_out_track = r_out_track;
        n_out_has   = r_out_has;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        mem_we      = 1'b0;
        mem_waddr   = r_pos[AW-1:0];
        mem_wdata   = r_track;
        mem_raddr   = r_idx;
        ins_done    = 1'b0;
        finish      = 1'b0;
        seek_cmd    = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_track = i_request_track;
                    n_head  = i_head_position;
                    n_last  = i_last_request;
                    n_state = S_INS;
                end
            end
            S_INS: begin
                mem_raddr = r_count - CW'(1);
                if (!track_ok) begin
                    ins_done = 1'b1;
                end else if (r_count == CW'(MAX_REQUESTS)) begin
                    n_dropped = 1'b1;
                    ins_done  = 1'b1;
                end else if (r_count == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    n_count   = r_count + CW'(1);
                    ins_done  = 1'b1;
                end else begin
                    n_pos   = r_count;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                mem_raddr = r_pos - CW'(2);
                mem_we    = 1'b1;
                if (r_rdata > r_track) begin
                    mem_wdata = r_rdata;
                    n_pos     = r_pos - CW'(1);
                    if (r_pos == CW'(1)) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    n_count  = r_count + CW'(1);
                    ins_done = 1'b1;
                end
            end
            S_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                n_count   = r_count + CW'(1);
                ins_done  = 1'b1;
            end
            S_SCAN: begin
                n_pend = r_idx < r_count;
                if (r_idx < r_count) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_pend) begin
                    if (r_rdata < r_head) begin
                        n_lt = r_lt + CW'(1);
                    end
                    if (r_rdata <= r_head) begin
                        n_le = r_le + CW'(1);
                    end
                end
                if (!(r_idx < r_count) && !r_pend) begin
                    if ((r_le == r_count) && (r_lt == '0)) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_state     = S_EMIT;
                        n_idx       = r_le;
                        n_phase     = 1'b0;
                        n_pend_last = 1'b0;
                    end
                end
            end
            S_EMIT: begin
                n_pend      = 1'b0;
                n_pend_last = 1'b0;
                if (!r_phase) begin
                    if (r_idx < r_count) begin
                        n_pend      = 1'b1;
                        n_pend_last = ((r_idx + CW'(1)) == r_count) && (r_lt == '0);
                        n_idx       = r_idx + CW'(1);
                    end else begin
                        n_phase = 1'b1;
                        n_idx   = '0;
                    end
                end else if (r_idx < r_lt) begin
                    n_pend      = 1'b1;
                    n_pend_last = (r_idx + CW'(1)) == r_lt;
                    n_idx       = r_idx + CW'(1);
                end
                if (r_pend) begin
                    seek_cmd.step  = 1'b1;
                    seek_cmd.track = r_rdata;
                    n_out_valid    = 1'b1;
                    n_out_track    = r_rdata;
                    n_out_has      = 1'b1;
                    n_out_last     = r_pend_last;
                    n_out_ovf      = r_dropped;
                    finish         = r_pend_last;
                end
            end
            S_EMPTY: begin
                n_out_valid = 1'b1;
                n_out_track = '0;
                n_out_has   = 1'b0;
                n_out_last  = 1'b1;
                n_out_ovf   = r_dropped;
                finish      = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ins_done) begin
            if (r_last) begin
                n_state        = S_SCAN;
                n_idx          = '0;
                n_pend         = 1'b0;
                n_lt           = '0;
                n_le           = '0;
                seek_cmd.load  = 1'b1;
                seek_cmd.track = r_head;
            end else begin
                n_state = S_IDLE;
            end
        end

        if (finish) begin
            n_state     = S_IDLE;
            n_count     = '0;
            n_dropped   = 1'b0;
            n_pend      = 1'b0;
            n_pend_last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_lt        <= '0;
            r_le        <= '0;
            r_phase     <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_lt        <= n_lt;
            r_le        <= n_le;
            r_phase     <= n_phase;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_track     <= n_track;
        r_head      <= n_head;
        r_last      <= n_last;
        r_out_track <= n_out_track;
        r_out_has   <= n_out_has;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    clook_seek u_seek (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (seek_cmd),
        .o_total (o_seek_total)
    );

    assign busy            = r_state != S_IDLE;
    assign o_valid         = r_out_valid;
    assign o_service_track = r_out_track;
    assign o_has_track     = r_out_has;
    assign o_last_in_run   = r_out_last;
    assign o_overflow_flag = r_out_ovf;

    `CLOOK_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_REQUESTS))
    `CLOOK_ASSERT(a_split_order, i_clk, i_rst_n, (r_state == S_EMIT) |-> (r_lt <= r_le))
    `CLOOK_ASSERT(a_run_end_clears, i_clk, i_rst_n,
                  (o_valid && o_last_in_run) |-> ((r_count == '0) && !r_dropped))
    `CLOOK_ASSERT(a_empty_result, i_clk, i_rst_n,
                  (o_valid && !o_has_track) |-> (o_last_in_run && (o_seek_total == '0)))
    `CLOOK_ASSERT(a_result_from_busy, i_clk, i_rst_n, o_valid |-> $past(busy))

endmodule

/* hdl/clook_seek.sv */
`include "clook_disk_scheduler_top_macros.svh"

module clook_seek (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clook_pkg::t_seek_cmd          i_cmd,
    output logic [clook_pkg::SEEK_W-1:0]  o_total
);

    logic [clook_pkg::TRACK_W-1:0] r_head;
    logic [clook_pkg::TRACK_W-1:0] n_head;
    logic [clook_pkg::SEEK_W-1:0]  r_total;
    logic [clook_pkg::SEEK_W-1:0]  n_total;
    logic [clook_pkg::TRACK_W-1:0] delta;
    logic [clook_pkg::SEEK_W:0]    sum;

    always_comb begin
        delta = (i_cmd.track >= r_head) ? (i_cmd.track - r_head) : (r_head - i_cmd.track);
        sum   = {1'b0, r_total} + (clook_pkg::SEEK_W + 1)'(delta);
        n_head  = r_head;
        n_total = r_total;
        if (i_cmd.load) begin
            n_head  = i_cmd.track;
            n_total = '0;
        end else if (i_cmd.step) begin
            n_head = i_cmd.track;
            if (sum > (clook_pkg::SEEK_W + 1)'(clook_pkg::SEEK_MAX)) begin
                n_total = clook_pkg::SEEK_MAX;
            end else begin
                n_total = sum[clook_pkg::SEEK_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_total <= '0;
        end else begin
            r_head  <= n_head;
            r_total <= n_total;
        end
    end

    assign o_total = r_total;

    `CLOOK_ASSERT_NEXT(a_load_clears, i_clk, i_rst_n, i_cmd.load, o_total == '0)
    `CLOOK_ASSERT_NEXT(a_total_grows, i_clk, i_rst_n, i_cmd.step && !i_cmd.load,
                       o_total >= $past(o_total))
    `CLOOK_ASSERT_NEXT(a_head_follows, i_clk, i_rst_n, i_cmd.step || i_cmd.load,
                       r_head == $past(i_cmd.track))

endmodule

/* sim/clook_disk_scheduler_top_test.sv */
`timescale 1ns / 1ps

module clook_disk_scheduler_top_test;

    localparam int TRACK_W        = clook_pkg::TRACK_W;
    localparam int SEEK_W         = clook_pkg::SEEK_W;
    localparam int SEEK_LIMIT     = int'(clook_pkg::SEEK_MAX);
    localparam int MAX_REQ        = clook_pkg::MAX_REQUESTS_DEF;
    localparam int RANDOM_ITEMS   = 280;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic               has_track;
        logic [SEEK_W-1:0]  seek_total;
        logic               last_in_run;
        logic               overflow;
    } t_service;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [TRACK_W-1:0] i_request_track = '0;
    logic [TRACK_W-1:0] i_head_position = '0;
    logic               i_last_request = 1'b0;
    logic               busy;
    logic               o_valid;
    logic [TRACK_W-1:0] o_service_track;
    logic               o_has_track;
    logic [SEEK_W-1:0]  o_seek_total;
    logic               o_last_in_run;
    logic               o_overflow_flag;

    logic [TRACK_W-1:0] batch_tracks[$];
    logic               batch_dropped = 1'b0;
    t_service           pending_services[$];

    int mismatches      = 0;
    int requests_sent   = 0;
    int batches_sent    = 0;
    int overflow_runs   = 0;
    int services_seen   = 0;
    int idle_cycles     = 0;
    bit gapless_stretch = 1'b0;

    clook_disk_scheduler_top #(
        .MAX_REQUESTS(MAX_REQ)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_request_track(i_request_track),
        .i_head_position(i_head_position),
        .i_last_request (i_last_request),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_service_track(o_service_track),
        .o_has_track    (o_has_track),
        .o_seek_total   (o_seek_total),
        .o_last_in_run  (o_last_in_run),
        .o_overflow_flag(o_overflow_flag)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [SEEK_W-1:0] want,
                                   input logic [SEEK_W-1:0] got);
        $display("%0t ns MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    task automatic emit_clook_schedule(input logic [TRACK_W-1:0] head);
        logic [TRACK_W-1:0] order[$];
        logic [TRACK_W-1:0] position;
        int                 total;
        t_service           svc;
        foreach (batch_tracks[i])
            if (batch_tracks[i] > head) order.push_back(batch_tracks[i]);
        foreach (batch_tracks[i])
            if (batch_tracks[i] < head) order.push_back(batch_tracks[i]);
        position = head;
        total    = 0;
        if (order.size() == 0) begin
            svc.track       = '0;
            svc.has_track   = 1'b0;
            svc.seek_total  = '0;
            svc.last_in_run = 1'b1;
            svc.overflow    = batch_dropped;
            pending_services.push_back(svc);
        end
        foreach (order[i]) begin
            total += (order[i] > position) ? int'(order[i]) - int'(position)
                                           : int'(position) - int'(order[i]);
            if (total > SEEK_LIMIT) total = SEEK_LIMIT;
            position        = order[i];
            svc.track       = order[i];
            svc.has_track   = 1'b1;
            svc.seek_total  = total[SEEK_W-1:0];
            svc.last_in_run = (i == order.size() - 1);
            svc.overflow    = batch_dropped;
            pending_services.push_back(svc);
        end
        if (batch_dropped) overflow_runs++;
        batches_sent++;
        batch_tracks.delete();
        batch_dropped = 1'b0;
    endtask

    task automatic apply_request(input logic [TRACK_W-1:0] track,
                                 input logic [TRACK_W-1:0] head, input logic last);
        if (batch_tracks.size() >= MAX_REQ) begin
            batch_dropped = 1'b1;
        end else begin
            batch_tracks.push_back(track);
            batch_tracks.sort();
        end
        if (last) emit_clook_schedule(head);
    endtask

    task automatic send_request(input logic [TRACK_W-1:0] track,
                                input logic [TRACK_W-1:0] head, input logic last);
        start           <= 1'b1;
        i_request_track <= track;
        i_head_position <= head;
        i_last_request  <= last;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_request(track, head, last);
        requests_sent++;
    endtask

    function automatic int gap_cycles();
        int r;
        if (gapless_stretch) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            start           <= 1'b0;
            i_request_track <= TRACK_W'($urandom_range(0, 255));
            i_head_position <= TRACK_W'($urandom_range(0, 255));
            i_last_request  <= 1'($urandom_range(0, 1));
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic send_and_idle(input logic [TRACK_W-1:0] track,
                                 input logic [TRACK_W-1:0] head, input logic last);
        send_request(track, head, last);
        idle_sender(gap_cycles());
    endtask

    task automatic test_empty_batches();
        send_and_idle(8'd77, 8'd77, 1'b1);
    endtask

    task automatic test_extreme_tracks();
        send_and_idle(8'd0, 8'd255, 1'b1);
        send_and_idle(8'd255, 8'd0, 1'b1);
        send_and_idle(8'd255, 8'd255, 1'b1);
    endtask

    task automatic test_no_lower_requests();
        send_and_idle(8'd200, 8'd13, 1'b0);
        send_and_idle(8'd100, 8'd240, 1'b0);
        send_and_idle(8'd150, 8'd50, 1'b1);
    endtask

    task automatic test_only_lower_requests();
        send_and_idle(8'd10, 8'd0, 1'b0);
        send_and_idle(8'd30, 8'd0, 1'b0);
        send_and_idle(8'd20, 8'd200, 1'b1);
    endtask

    task automatic test_wrap_with_duplicates();
        send_and_idle(8'd40, 8'd0, 1'b0);
        send_and_idle(8'd90, 8'd0, 1'b0);
        send_and_idle(8'd90, 8'd0, 1'b0);
        send_and_idle(8'd60, 8'd0, 1'b0);
        send_and_idle(8'd20, 8'd60, 1'b1);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < MAX_REQ + 2; i++)
            send_and_idle(8'(255 - 23 * i), 8'd128, i == MAX_REQ + 1);
    endtask

    task automatic test_random_batches();
        logic [TRACK_W-1:0] tracks[$];
        logic [TRACK_W-1:0] head;
        logic [TRACK_W-1:0] base;
        int                 size;
        int                 r;
        bit                 narrow;
        while (requests_sent < RANDOM_ITEMS) begin
            tracks.delete();
            gapless_stretch = ($urandom_range(0, 3) == 0);
            size   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, MAX_REQ)
                                                  : $urandom_range(MAX_REQ + 1, MAX_REQ + 4);
            narrow = ($urandom_range(0, 2) == 0);
            base   = TRACK_W'($urandom_range(0, 255));
            for (int i = 0; i < size; i++)
                tracks.push_back(narrow ? 8'(base + $urandom_range(0, 3))
                                        : 8'($urandom_range(0, 255)));
            r = $urandom_range(0, 9);
            if (r < 5)      head = TRACK_W'($urandom_range(0, 255));
            else if (r < 8) head = tracks[$urandom_range(0, size - 1)];
            else            head = (r == 8) ? 8'd0 : 8'd255;
            for (int i = 0; i < size - 1; i++)
                send_and_idle(tracks[i], TRACK_W'($urandom_range(0, 255)), 1'b0);
            send_and_idle(tracks[size - 1], head, 1'b1);
        end
        gapless_stretch = 1'b0;
    endtask

    always @(posedge i_clk) begin : check_services
        t_service want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_services.size() == 0) begin
                report_mismatch("result with nothing pending", '0,
                                SEEK_W'(o_service_track));
            end else begin
                want = pending_services.pop_front();
                services_seen++;
                if (o_service_track !== want.track)
                    report_mismatch("service_track", SEEK_W'(want.track),
                                    SEEK_W'(o_service_track));
                if (o_has_track !== want.has_track)
                    report_mismatch("has_track", SEEK_W'(want.has_track),
                                    SEEK_W'(o_has_track));
                if (o_seek_total !== want.seek_total)
                    report_mismatch("seek_total", want.seek_total, o_seek_total);
                if (o_last_in_run !== want.last_in_run)
                    report_mismatch("last_in_run", SEEK_W'(want.last_in_run),
                                    SEEK_W'(o_last_in_run));
                if (o_overflow_flag !== want.overflow)
                    report_mismatch("overflow_flag", SEEK_W'(want.overflow),
                                    SEEK_W'(o_overflow_flag));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("clook_disk_scheduler_top_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_empty_batches();
        test_extreme_tracks();
        test_no_lower_requests();
        test_only_lower_requests();
        test_wrap_with_duplicates();
        test_overflow();
        test_random_batches();
        start <= 1'b0;
        while (pending_services.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d requests in %0d batches (%0d with dropped requests).",
                 requests_sent, batches_sent, overflow_runs);
        $display("Checked %0d scheduled tracks, %0d mismatches.", services_seen, mismatches);
        if (mismatches == 0) begin
            $display("clook_disk_scheduler_top_test passed");
        end else begin
            $display("clook_disk_scheduler_top_test failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/clook_pkg.sv
hdl/clook_seek.sv
hdl/clook_disk_scheduler_top.sv
sim/clook_disk_scheduler_top_test.sv
